// ===== rtl/core/ptd_pkg.sv =====
// Shared types and constants for the trial-division primality tester.
// Used by ptd_ctrl, ptd_dpath and primality_trial_division; no dependencies.
package ptd_pkg;

   // first trial divisor, distance to its partner and step between pairs
   localparam int PTD_FIRST_DIV = 5;
   localparam int PTD_PAIR_OFS  = 2;
   localparam int PTD_STEP      = 6;
   localparam int PTD_SMALL_DIV = 3;

   typedef enum logic [1:0] {
      DIV_SEL_D     = 2'd0,
      DIV_SEL_D2    = 2'd1,
      DIV_SEL_NEXT  = 2'd2
   } ptd_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_start;
      ptd_sel_type sel;
   } ptd_cmd_type;

   typedef struct packed {
      logic pre_done;
      logic pre_prime;
      logic mult3;
      logic div_done;
      logic rem_zero;
      logic q_ge_d;
   } ptd_stat_type;

endpackage

// ===== rtl/core/ptd_dpath.sv =====
// Datapath: operand register, candidate divisor and a restoring serial divider.
// Depends on ptd_pkg; driven by ptd_ctrl through ptd_cmd_type.
module ptd_dpath import ptd_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [WIDTH-1:0] number,
   input  ptd_cmd_type      cmd,
   output ptd_stat_type     stat
);

   localparam int CW    = $clog2(WIDTH);
   localparam int NDIG  = (WIDTH + 1) / 2;
   localparam int NLEAF = 1 << $clog2(NDIG);
   localparam int PADW  = 2 * NLEAF;

   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] d_ff, d_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             active_ff, active_in;
   logic             done_ff, done_in;

   logic [WIDTH-1:0] dvs_sel;
   logic [WIDTH:0]   shift;
   logic [WIDTH:0]   diff;
   logic             ge;

   logic [PADW-1:0]  n_pad;
   logic [1:0]       res [NLEAF];
   logic             mult3;

   function automatic logic [1:0] add_mod3(logic [1:0] a, logic [1:0] b);
      logic [2:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return (sum >= 3'd3) ? 2'(sum - 3'd3) : sum[1:0];
   endfunction

   // 4 is 1 mod 3: fold the base-4 digits of the operand in a tree
   always_comb begin
      n_pad = PADW'(n_ff);
      for (int i = 0; i < NLEAF; i++) begin
         res[i] = (n_pad[2*i +: 2] == 2'd3) ? 2'd0 : n_pad[2*i +: 2];
      end
      for (int span = 1; span < NLEAF; span = span * 2) begin
         for (int i = 0; i + span < NLEAF; i = i + 2 * span) begin
            res[i] = add_mod3(res[i], res[i + span]);
         end
      end
      mult3 = (res[0] == 2'd0);
   end

   always_comb begin
      unique case (cmd.sel)
         DIV_SEL_D:     dvs_sel = d_ff;
         DIV_SEL_D2:    dvs_sel = d_ff + WIDTH'(PTD_PAIR_OFS);
         DIV_SEL_NEXT:  dvs_sel = d_ff + WIDTH'(PTD_STEP);
         default:       dvs_sel = d_ff;
      endcase
   end

   assign shift = {rem_ff, quo_ff[WIDTH-1]};
   assign diff  = shift - {1'b0, dvs_ff};
   assign ge    = shift >= {1'b0, dvs_ff};

   always_comb begin
      n_in      = n_ff;
      d_in      = d_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (cmd.load) begin
         n_in = number;
         d_in = WIDTH'(PTD_FIRST_DIV);
      end
      if (cmd.div_start) begin
         rem_in    = '0;
         quo_in    = n_ff;
         dvs_in    = dvs_sel;
         cnt_in    = CW'(WIDTH - 1);
         active_in = 1'b1;
         // advance to the next pair as its first division starts
         if (cmd.sel == DIV_SEL_NEXT) begin
            d_in = dvs_sel;
         end
      end else if (active_ff) begin
         rem_in = ge ? diff[WIDTH-1:0] : shift[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_comb begin
      stat.pre_done  = n_ff[WIDTH-1] || (n_ff <= WIDTH'(PTD_SMALL_DIV)) || !n_ff[0];
      stat.pre_prime = !n_ff[WIDTH-1] &&
                       ((n_ff == WIDTH'(2)) || (n_ff == WIDTH'(PTD_SMALL_DIV)));
      stat.mult3     = mult3;
      stat.div_done  = done_ff;
      stat.rem_zero  = (rem_ff == '0);
      stat.q_ge_d    = (quo_ff >= d_ff);
   end

`ifndef SYNTH
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !active_ff)
      else $error("division started while divider busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("division done held for more than one cycle");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dvs_ff))
      else $error("remainder not below divisor");
`endif

endmodule

// ===== rtl/core/ptd_ctrl.sv =====
// Controller: sequences classification and the candidate divisor pairs.
// Depends on ptd_pkg; commands ptd_dpath and drives the response strobe.
module ptd_ctrl import ptd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_strobe,
   output logic         rsp_is_prime,
   output ptd_cmd_type  cmd,
   input  ptd_stat_type stat
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CLASS = 4'b0010,
      ST_DIVA  = 4'b0100,
      ST_DIVB  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;
   logic      prime_ff, prime_in;

   always_comb begin
      state_in      = state_ff;
      strobe_in     = 1'b0;
      prime_in      = prime_ff;
      cmd.load      = 1'b0;
      cmd.div_start = 1'b0;
      cmd.sel       = DIV_SEL_D;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CLASS;
            end
         end
         ST_CLASS: begin
            priority if (stat.pre_done) begin
               strobe_in = 1'b1;
               prime_in  = stat.pre_prime;
               state_in  = ST_IDLE;
            end else if (stat.mult3) begin
               strobe_in = 1'b1;
               prime_in  = 1'b0;
               state_in  = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.sel       = DIV_SEL_D;
               state_in      = ST_DIVA;
            end
         end
         ST_DIVA: begin
            // quotient below d means d*d > n: no divisor left to try
            if (stat.div_done) begin
               priority if (!stat.q_ge_d) begin
                  strobe_in = 1'b1;
                  prime_in  = 1'b1;
                  state_in  = ST_IDLE;
               end else if (stat.rem_zero) begin
                  strobe_in = 1'b1;
                  prime_in  = 1'b0;
                  state_in  = ST_IDLE;
               end else begin
                  cmd.div_start = 1'b1;
                  cmd.sel       = DIV_SEL_D2;
                  state_in      = ST_DIVB;
               end
            end
         end
         ST_DIVB: begin
            if (stat.div_done) begin
               if (stat.rem_zero) begin
                  strobe_in = 1'b1;
                  prime_in  = 1'b0;
                  state_in  = ST_IDLE;
               end else begin
                  cmd.div_start = 1'b1;
                  cmd.sel       = DIV_SEL_NEXT;
                  state_in      = ST_DIVA;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         prime_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         prime_ff  <= prime_in;
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = strobe_ff;
   assign rsp_is_prime = prime_ff;

`ifndef SYNTH
   a_idle_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response given while still busy");
   a_take: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("accepted transaction did not raise busy");
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a transaction in progress");
`endif

endmodule

// ===== rtl/core/primality_trial_division.sv =====
// Top level of the trial-division primality tester.
// Depends on ptd_pkg, ptd_ctrl and ptd_dpath.
//
// Usage:
//   Drive req_number and raise start while busy is low; the transaction is
//   taken on that clock edge and busy rises on the next cycle. When the test
//   ends, rsp_strobe is high for exactly one cycle with rsp_is_prime valid,
//   and busy falls in that same cycle, so a new start may be given at once.
//   The receiver cannot stall: a response must be captured when strobed.
// Test sequence:
//   Negative, small and even values and multiples of three are answered
//   from the classification state, without a division. Otherwise each
//   remainder is formed in the shared serial divider (one quotient bit per
//   cycle), for d and d+2 of each pair, until a remainder is zero or
//   the quotient by d falls below d. For WIDTH = 32 about 7700 pairs at most.
//   One transaction is in flight at a time: start is taken only while idle.
// Reset:
//   Synchronous, active high; returns the controller to idle, drops any
//   transaction in progress and clears the response strobe.
module primality_trial_division import ptd_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [WIDTH-1:0] req_number,
   output logic                    rsp_strobe,
   output logic                    rsp_is_prime
);

   ptd_cmd_type  cmd;
   ptd_stat_type stat;

   ptd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .rsp_strobe   (rsp_strobe),
      .rsp_is_prime (rsp_is_prime),
      .cmd          (cmd),
      .stat         (stat)
   );

   ptd_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .number ($unsigned(req_number)),
      .cmd    (cmd),
      .stat   (stat)
   );

endmodule
